/* src/upq_pkg.sv */
package upq_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 16;
    localparam int KEY_W    = 32;
    localparam int OUT_CNT_W = 11;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_FIND     = 2'd1,
        CMD_EXTRACT  = 2'd2,
        CMD_DECREASE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic finish;
    } upq_ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic last_addr;
    } upq_stat_t;

endpackage

/* src/upq_ctrl.sv */
module upq_ctrl
    import upq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic [1:0] command,
    input  upq_stat_t stat,
    output upq_ctrl_t ctl,
    output logic      busy
);

    state_t state_reg;
    state_t state_next;
    cmd_t   cmd_in;

    assign cmd_in = cmd_t'(command);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // insert and any op on an empty store need no scan
                    if (cmd_in inside {CMD_INSERT} || stat.empty)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (stat.last_addr)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:   state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.load   = 1'b0;
        ctl.rd_en  = 1'b0;
        ctl.finish = 1'b0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.load = start;
                busy     = 1'b0;
            end
            ST_SCAN:   ctl.rd_en  = 1'b1;
            ST_WAIT:   ;
            ST_FINISH: ctl.finish = 1'b1;
            default:   ;
        endcase
    end

endmodule

/* src/upq_dp.sv */
module upq_dp
    import upq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  upq_ctrl_t               ctl,
    input  logic [1:0]              command,
    input  logic [ID_W-1:0]         item_id,
    input  logic signed [KEY_W-1:0] item_key,
    output upq_stat_t               stat,
    output logic                    done,
    output logic                    ok,
    output logic [ID_W-1:0]         result_id,
    output logic signed [KEY_W-1:0] result_key,
    output logic [OUT_CNT_W-1:0]    entry_count
);

    logic [ID_W+KEY_W-1:0] mem [CAPACITY];

    cmd_t                    cmd_reg;
    logic [ID_W-1:0]         id_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [ADDR_W-1:0]       addr_reg;
    logic [ADDR_W-1:0]       last_idx;

    logic                    rd_vld_reg;
    logic [ADDR_W-1:0]       rd_idx_reg;
    logic [ID_W-1:0]         rd_id;
    logic signed [KEY_W-1:0] rd_key;
    logic [ID_W+KEY_W-1:0]   rd_data_reg;

    logic                    best_vld_reg;
    logic [ADDR_W-1:0]       best_idx_reg;
    logic [ID_W-1:0]         best_id_reg;
    logic signed [KEY_W-1:0] best_key_reg;
    logic [ID_W+KEY_W-1:0]   last_data_reg;

    logic                    found_reg;
    logic                    accept_reg;
    logic [ADDR_W-1:0]       match_idx_reg;

    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ID_W+KEY_W-1:0]   wr_data;
    logic                    ok_next;
    logic [ID_W-1:0]         rid_next;
    logic signed [KEY_W-1:0] rkey_next;

    logic                    done_reg;
    logic                    ok_reg;
    logic [ID_W-1:0]         rid_reg;
    logic signed [KEY_W-1:0] rkey_reg;

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CNT_W'(CAPACITY));
    assign last_idx       = ADDR_W'(count_reg - CNT_W'(1));
    assign stat.last_addr = (addr_reg == last_idx);

    assign rd_id  = rd_data_reg[ID_W+KEY_W-1:KEY_W];
    assign rd_key = $signed(rd_data_reg[KEY_W-1:0]);

    // operand capture and read address
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd_t'(command);
            id_reg   <= item_id;
            key_reg  <= item_key;
            addr_reg <= '0;
        end
        else if (ctl.rd_en)
        begin
            addr_reg <= addr_reg + ADDR_W'(1);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr_reg];
            rd_idx_reg  <= addr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= ctl.rd_en;
            if (ctl.load)
            begin
                best_vld_reg <= 1'b0;
                found_reg    <= 1'b0;
            end
            else if (rd_vld_reg)
            begin
                best_vld_reg <= 1'b1;
                if (!found_reg && rd_id == id_reg)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // scan compare stage: strict less keeps the lowest index on ties
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            if (!best_vld_reg || rd_key < best_key_reg)
            begin
                best_idx_reg <= rd_idx_reg;
                best_id_reg  <= rd_id;
                best_key_reg <= rd_key;
            end
            if (rd_idx_reg == last_idx)
            begin
                last_data_reg <= rd_data_reg;
            end
            if (!found_reg && rd_id == id_reg)
            begin
                match_idx_reg <= rd_idx_reg;
                accept_reg    <= !(rd_key < key_reg);
            end
        end
    end

    // finish step: at most one memory write, and the live count update
    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = {id_reg, key_reg};
        ok_next    = 1'b0;
        rid_next   = '0;
        rkey_next  = '0;
        count_next = count_reg;
        if (ctl.finish)
        begin
            case (cmd_reg)
                CMD_INSERT:
                begin
                    if (!stat.full)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = ADDR_W'(count_reg);
                        ok_next    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_FIND, CMD_EXTRACT:
                begin
                    if (!stat.empty)
                    begin
                        ok_next   = 1'b1;
                        rid_next  = best_id_reg;
                        rkey_next = best_key_reg;
                        if (cmd_reg == CMD_EXTRACT)
                        begin
                            // last entry fills the hole
                            wr_en      = 1'b1;
                            wr_addr    = best_idx_reg;
                            wr_data    = last_data_reg;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                CMD_DECREASE:
                begin
                    if (!stat.empty && found_reg && accept_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = match_idx_reg;
                        ok_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= ctl.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            ok_reg   <= ok_next;
            rid_reg  <= rid_next;
            rkey_reg <= rkey_next;
        end
    end

    assign done        = done_reg;
    assign ok          = ok_reg;
    assign result_id   = rid_reg;
    assign result_key  = rkey_reg;
    assign entry_count = OUT_CNT_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("live count above capacity");

    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(ctl.finish))
        else $error("result strobe without finish step");

    a_extract_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.finish && cmd_reg == CMD_EXTRACT && !stat.empty)
        |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("extract did not remove an entry");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.finish |=> $stable(count_reg))
        else $error("live count changed outside finish step");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_en |-> (CNT_W'(addr_reg) < count_reg))
        else $error("scan read beyond live entries");

endmodule

/* src/unsorted_array_min_priority_queue_unit.sv */
// Min priority queue over an unordered array of (id, key) entries.
// Command channel: a transfer happens at a clock edge with start high and
// busy low; command, item_id and item_key are sampled there.
// Result channel: done is high for one cycle with ok, result_id, result_key
// and entry_count; the receiver must take it in that cycle.
// Insert, or any command on an empty queue, goes straight to the finish
// step; find, extract and decrease key first scan every live entry, one
// entry per cycle through the single read port of the entry memory, then
// pass a wait state before the finish step.
// busy drops in the cycle done rises, so a new command can transfer then.
// Ties on the minimum key go to the lower index. Extract moves the last
// entry into the freed slot. Decrease key touches only the first entry with
// a matching id, and only when the new key is not larger.
// Reset empties the queue at once (count cleared, no memory sweep).
module unsorted_array_min_priority_queue_unit
    import upq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              command,
    input  logic [ID_W-1:0]         item_id,
    input  logic signed [KEY_W-1:0] item_key,
    output logic                    done,
    output logic                    ok,
    output logic [ID_W-1:0]         result_id,
    output logic signed [KEY_W-1:0] result_key,
    output logic [OUT_CNT_W-1:0]    entry_count
);

    upq_ctrl_t ctl;
    upq_stat_t stat;

    upq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .ctl     (ctl),
        .busy    (busy)
    );

    upq_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .command     (command),
        .item_id     (item_id),
        .item_key    (item_key),
        .stat        (stat),
        .done        (done),
        .ok          (ok),
        .result_id   (result_id),
        .result_key  (result_key),
        .entry_count (entry_count)
    );

endmodule
